// ===== hw/rtl/timebin_sync_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// Timebin scheduler assertion macros
// Concurrent assertion wrappers, clocked on i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef TIMEBIN_SYNC_SCHEDULER_ASSERT_SVH
`define TIMEBIN_SYNC_SCHEDULER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TSS_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("tss assertion failed");

`define TSS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tss assertion failed");

`define TSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tss assertion failed");

`else

`define TSS_ASSERT(label, expr)
`define TSS_ASSERT_IMPLIES(label, ante, cons)
`define TSS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// Timebin scheduler package
// Widths, constants, word types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int NUM_BINS = 29;
    localparam int BIN_W    = 5;
    localparam int CNT_W    = 25;
    localparam int TIME_W   = 30;
    localparam int SUM_W    = 30;
    localparam int NEXT_W   = 31;
    localparam int FRAC_W   = 17;
    localparam int PROD_W   = 47;
    localparam int FRAC_SH  = 16;

    localparam logic [CNT_W-1:0]  MAX_PARTICLES = CNT_W'(16777216);
    localparam logic [FRAC_W-1:0] FRAC_RESET    = FRAC_W'(6554);
    localparam logic [BIN_W-1:0]  LAST_BIN      = BIN_W'(NUM_BINS - 1);
    localparam logic [BIN_W-1:0]  NO_BIN        = BIN_W'(NUM_BINS);
    localparam logic [NEXT_W-1:0] TIMEBASE      = NEXT_W'(1) << NUM_BINS;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_COUNT = 2'd1;
    localparam logic [1:0] OP_SYNC  = 2'd2;
    localparam logic [1:0] OP_MARK  = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BIN_W-1:0]  gravity_bin;
        logic              is_gas;
        logic [BIN_W-1:0]  hydro_bin;
        logic [TIME_W-1:0] current_time;
    } t_in_word;

    typedef struct packed {
        logic [TIME_W-1:0]   next_sync_time;
        logic [NUM_BINS-1:0] synchronized_mask;
        logic [BIN_W-1:0]    lowest_occupied;
        logic [BIN_W-1:0]    highest_occupied;
        logic [BIN_W-1:0]    lowest_occupied_gravity;
        logic [BIN_W-1:0]    highest_occupied_gravity;
        logic [BIN_W-1:0]    lowest_active;
        logic [BIN_W-1:0]    highest_active;
        logic [BIN_W-1:0]    highest_synchronized;
        logic [CNT_W-1:0]    synced_gravity_count;
        logic [CNT_W-1:0]    synced_hydro_count;
        logic [BIN_W-1:0]    decomp_bin;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic count;
        logic load;
        logic step1;
        logic mul;
        logic step2;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_bin;
        logic op_sync;
    } t_dp_stat;

endpackage

// ===== hw/rtl/tss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Timebin scheduler controller
// Sequences clear/count words and the bin sweeps, owns the output valid.
// ----------------------------------------------------------------------------
`include "timebin_sync_scheduler_assert.svh"

module tss_ctrl
    import tss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PASS1 = 5'b00010,
        S_MUL   = 5'b00100,
        S_PASS2 = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_operation)
                        OP_CLEAR: o_cmd.clear = 1'b1;
                        OP_COUNT: o_cmd.count = 1'b1;
                        default: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_PASS1;
                        end
                    endcase
                end
            end
            S_PASS1: begin
                o_cmd.step1 = 1'b1;
                if (i_stat.last_bin) begin
                    n_state = i_stat.op_sync ? S_EMIT : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PASS2;
            end
            S_PASS2: begin
                o_cmd.step2 = 1'b1;
                if (i_stat.last_bin) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `TSS_ASSERT_NEXT(a_emit_valid, o_cmd.emit, o_out_valid)
    `TSS_ASSERT_IMPLIES(a_busy_no_take, r_state != S_IDLE, !(o_cmd.count || o_cmd.clear || o_cmd.load))
    `TSS_ASSERT_IMPLIES(a_emit_free, o_cmd.emit, !r_out_valid || i_out_ready)

endmodule

// ===== hw/rtl/tss_datapath.sv =====
// ----------------------------------------------------------------------------
// Timebin scheduler datapath
// Per-bin counts, fraction register, sweep accumulators and result register.
// ----------------------------------------------------------------------------
`include "timebin_sync_scheduler_assert.svh"

module tss_datapath
    import tss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_word          i_in_word,
    input  logic              i_cfg_wr_en,
    input  logic [FRAC_W-1:0] i_cfg_wr_data,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output t_out_word         o_out_word
);

    logic [CNT_W-1:0]    r_gcnt [NUM_BINS];
    logic [CNT_W-1:0]    r_hcnt [NUM_BINS];
    logic [NUM_BINS-1:0] r_gvld;
    logic [NUM_BINS-1:0] r_hvld;
    logic [FRAC_W-1:0]   r_frac;

    logic                r_op_sync;
    logic [TIME_W-1:0]   r_time;
    logic [BIN_W-1:0]    r_idx;
    logic [TIME_W-1:0]   r_lm;
    logic                r_sync;
    logic [NEXT_W-1:0]   r_best;
    logic [NUM_BINS-1:0] r_mask;
    logic [BIN_W-1:0]    r_lo_occ, r_hi_occ, r_lo_grav, r_hi_grav;
    logic [BIN_W-1:0]    r_lo_act, r_hi_act, r_hi_sync, r_decomp;
    logic                r_found;
    logic [CNT_W-1:0]    r_syn_g, r_syn_h;
    logic [SUM_W-1:0]    r_tot_g, r_tot_h, r_cum_g, r_cum_h;
    logic [PROD_W-1:0]   r_thr_g, r_thr_h;
    t_out_word           r_out;

    logic [BIN_W-1:0]  g_addr, h_addr;
    logic [CNT_W-1:0]  g_rd, h_rd, g_inc, h_inc;
    logic              g_ok, h_ok, occ, in_range, hit;
    logic [NEXT_W-1:0] nxt;
    logic [CNT_W:0]    syn_g_sum, syn_h_sum;
    logic [CNT_W-1:0]  syn_g_sat, syn_h_sat;
    logic [SUM_W-1:0]  cum_g_sum, cum_h_sum;

    assign g_addr = i_cmd.count ? i_in_word.gravity_bin : r_idx;
    assign h_addr = i_cmd.count ? i_in_word.hydro_bin   : r_idx;
    assign g_ok   = i_in_word.gravity_bin <= LAST_BIN;
    assign h_ok   = i_in_word.is_gas && (i_in_word.hydro_bin <= LAST_BIN);

    assign g_rd  = r_gvld[g_addr] ? r_gcnt[g_addr] : '0;
    assign h_rd  = r_hvld[h_addr] ? r_hcnt[h_addr] : '0;
    assign g_inc = (g_rd < MAX_PARTICLES) ? g_rd + CNT_W'(1) : g_rd;
    assign h_inc = (h_rd < MAX_PARTICLES) ? h_rd + CNT_W'(1) : h_rd;

    assign occ = (g_rd != '0) || (h_rd != '0);

    // bin 0 kicks at t; bin n at (t with n low bits cleared) + 2^n
    assign nxt = (r_idx == '0) ? {1'b0, r_time}
               : ({1'b0, r_time & ~r_lm} + {1'b0, r_lm} + NEXT_W'(1));

    assign syn_g_sum = {1'b0, r_syn_g} + {1'b0, g_rd};
    assign syn_h_sum = {1'b0, r_syn_h} + {1'b0, h_rd};
    assign syn_g_sat = (syn_g_sum > {1'b0, MAX_PARTICLES}) ? MAX_PARTICLES
                                                          : syn_g_sum[CNT_W-1:0];
    assign syn_h_sat = (syn_h_sum > {1'b0, MAX_PARTICLES}) ? MAX_PARTICLES
                                                          : syn_h_sum[CNT_W-1:0];

    assign cum_g_sum = r_cum_g + SUM_W'(g_rd);
    assign cum_h_sum = r_cum_h + SUM_W'(h_rd);
    assign in_range  = (r_idx >= r_lo_occ) && (r_idx <= r_hi_occ);
    assign hit = ({1'b0, cum_g_sum, FRAC_SH'(0)} > r_thr_g)
              || ({1'b0, cum_h_sum, FRAC_SH'(0)} > r_thr_h);

    assign o_stat.last_bin = (r_idx == LAST_BIN);
    assign o_stat.op_sync  = r_op_sync;
    assign o_out_word      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvld <= '0;
            r_hvld <= '0;
            r_frac <= FRAC_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_frac <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_gvld <= '0;
                r_hvld <= '0;
            end else if (i_cmd.count) begin
                if (g_ok) begin
                    r_gvld[g_addr] <= 1'b1;
                end
                if (h_ok) begin
                    r_hvld[h_addr] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.count && g_ok) begin
            r_gcnt[g_addr] <= g_inc;
        end
        if (i_cmd.count && h_ok) begin
            r_hcnt[h_addr] <= h_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op_sync <= (i_in_word.operation == OP_SYNC);
            r_time    <= i_in_word.current_time;
            r_idx     <= '0;
            r_lm      <= '0;
            r_sync    <= 1'b1;
            r_best    <= TIMEBASE;
            r_mask    <= '0;
            r_lo_occ  <= NO_BIN;
            r_hi_occ  <= '0;
            r_lo_grav <= NO_BIN;
            r_hi_grav <= '0;
            r_lo_act  <= NO_BIN;
            r_hi_act  <= '0;
            r_hi_sync <= '0;
            r_syn_g   <= '0;
            r_syn_h   <= '0;
            r_tot_g   <= '0;
            r_tot_h   <= '0;
        end else if (i_cmd.step1) begin
            r_idx  <= o_stat.last_bin ? '0 : r_idx + BIN_W'(1);
            r_lm   <= {r_lm[TIME_W-2:0], 1'b1};
            r_sync <= r_sync & ~r_time[r_idx];
            if (occ && (nxt < r_best)) begin
                r_best <= nxt;
            end
            if (g_rd != '0) begin
                r_hi_grav <= r_idx;
                if (r_lo_grav == NO_BIN) begin
                    r_lo_grav <= r_idx;
                end
            end
            if (occ) begin
                r_hi_occ <= r_idx;
                if (r_lo_occ == NO_BIN) begin
                    r_lo_occ <= r_idx;
                end
            end
            if (r_sync) begin
                r_mask[r_idx] <= 1'b1;
                r_hi_sync     <= r_idx;
                r_syn_g       <= syn_g_sat;
                r_syn_h       <= syn_h_sat;
                if (occ) begin
                    r_hi_act <= r_idx;
                    if (r_lo_act == NO_BIN) begin
                        r_lo_act <= r_idx;
                    end
                end
            end
            r_tot_g <= r_tot_g + SUM_W'(g_rd);
            r_tot_h <= r_tot_h + SUM_W'(h_rd);
        end else if (i_cmd.mul) begin
            r_idx    <= '0;
            r_thr_g  <= PROD_W'(r_frac) * PROD_W'(r_tot_g);
            r_thr_h  <= PROD_W'(r_frac) * PROD_W'(r_tot_h);
            r_cum_g  <= '0;
            r_cum_h  <= '0;
            r_decomp <= r_hi_occ;
            r_found  <= 1'b0;
        end else if (i_cmd.step2) begin
            r_idx   <= o_stat.last_bin ? '0 : r_idx + BIN_W'(1);
            r_cum_g <= cum_g_sum;
            r_cum_h <= cum_h_sum;
            if (in_range && hit && !r_found) begin
                r_decomp <= r_idx;
                r_found  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_op_sync) begin
                r_out.next_sync_time           <= r_best[TIME_W-1:0];
                r_out.synchronized_mask        <= '0;
                r_out.lowest_occupied          <= '0;
                r_out.highest_occupied         <= '0;
                r_out.lowest_occupied_gravity  <= '0;
                r_out.highest_occupied_gravity <= '0;
                r_out.lowest_active            <= '0;
                r_out.highest_active           <= '0;
                r_out.highest_synchronized     <= '0;
                r_out.synced_gravity_count     <= '0;
                r_out.synced_hydro_count       <= '0;
                r_out.decomp_bin               <= '0;
            end else begin
                r_out.next_sync_time           <= '0;
                r_out.synchronized_mask        <= r_mask;
                r_out.lowest_occupied          <= r_lo_occ;
                r_out.highest_occupied         <= r_hi_occ;
                r_out.lowest_occupied_gravity  <= r_lo_grav;
                r_out.highest_occupied_gravity <= r_hi_grav;
                r_out.lowest_active            <= r_lo_act;
                r_out.highest_active           <= r_hi_act;
                r_out.highest_synchronized     <= r_hi_sync;
                r_out.synced_gravity_count     <= r_syn_g;
                r_out.synced_hydro_count       <= r_syn_h;
                r_out.decomp_bin               <= r_decomp;
            end
        end
    end

    `TSS_ASSERT_IMPLIES(a_idx_range, i_cmd.step1 || i_cmd.step2, r_idx <= LAST_BIN)
    `TSS_ASSERT_IMPLIES(a_occ_bounds, i_cmd.emit && !r_op_sync, (r_lo_occ <= r_hi_occ) || (r_lo_occ == NO_BIN))
    `TSS_ASSERT_IMPLIES(a_act_in_occ, i_cmd.emit && !r_op_sync && (r_lo_act != NO_BIN), (r_lo_act >= r_lo_occ) && (r_hi_act <= r_hi_occ))

endmodule

// ===== hw/rtl/timebin_sync_scheduler.sv =====
// ----------------------------------------------------------------------------
// Timebin sync scheduler top level
// Clear and count words are taken one per cycle, back to back while no sweep runs.
// Next-sync words: one sweep over the 29 bins, then the result is registered.
// Mark words: sweep, threshold multiply, second sweep; no new word is taken until the result is emitted.
// Synchronous active-low reset empties all bins at once, fraction resets to 6554.
// ----------------------------------------------------------------------------
module timebin_sync_scheduler
    import tss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word,
    input  logic              i_cfg_wr_en,
    input  logic [FRAC_W-1:0] i_cfg_wr_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_in_word.operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tss_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_word     (i_in_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_word    (o_out_word)
    );

endmodule

// ===== bench/tb_timebin_sync_scheduler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timebin sync scheduler testbench
// Feeds clear, count, next-sync and mark words through the valid/ready input
// channel with random idle bursts, and keeps a copy of the per-bin gravity and
// hydro counts. Each next-sync and mark result is predicted from that copy and
// checked field by field. The decomposition fraction is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_timebin_sync_scheduler;
    import tss_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 210;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in_word          in_word = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_word         out_word;
    logic              cfg_wr_en = 1'b0;
    logic [FRAC_W-1:0] cfg_wr_data = '0;

    logic [CNT_W-1:0]  bin_grav  [NUM_BINS];
    logic [CNT_W-1:0]  bin_hydro [NUM_BINS];
    logic [FRAC_W-1:0] frac_q16 = FRAC_RESET;

    t_in_word  word_backlog [$];
    t_out_word sync_reports [$];
    t_out_word want;

    int  words_queued   = 0;
    int  words_accepted = 0;
    int  fails          = 0;
    int  in_gap         = 0;
    int  out_gap        = 0;
    int  idle_cycles    = 0;
    bit  calm           = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    timebin_sync_scheduler u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_word     (in_word),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_word    (out_word),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // bin bookkeeping and result prediction for one accepted word
    task automatic sched_step(input t_in_word w, output bit has_rpt, output t_out_word rpt);
        longint unsigned t, best, nxt, frac;
        longint unsigned syn_g, syn_h, tot_g, tot_h;
        longint unsigned cum_g [NUM_BINS];
        longint unsigned cum_h [NUM_BINS];
        int n, lo_occ, hi_occ, lo_grv, hi_grv, lo_act, hi_act, hi_syn, dbin;
        bit occ, syn;
        has_rpt = 1'b0;
        rpt = '0;
        t = w.current_time;
        frac = frac_q16;
        case (w.operation)
            OP_CLEAR: begin
                for (n = 0; n < NUM_BINS; n++) begin
                    bin_grav[n] = '0;
                    bin_hydro[n] = '0;
                end
            end
            OP_COUNT: begin
                if (w.gravity_bin < NUM_BINS) begin
                    if (bin_grav[w.gravity_bin] < MAX_PARTICLES)
                        bin_grav[w.gravity_bin] = bin_grav[w.gravity_bin] + 1'b1;
                end
                if (w.is_gas && w.hydro_bin < NUM_BINS) begin
                    if (bin_hydro[w.hydro_bin] < MAX_PARTICLES)
                        bin_hydro[w.hydro_bin] = bin_hydro[w.hydro_bin] + 1'b1;
                end
            end
            OP_SYNC: begin
                has_rpt = 1'b1;
                best = 64'd1 << NUM_BINS;
                for (n = 0; n < NUM_BINS; n++) begin
                    if (bin_grav[n] != 0 || bin_hydro[n] != 0) begin
                        nxt = (n == 0) ? t : ((t >> n) << n) + (64'd1 << n);
                        if (nxt < best)
                            best = nxt;
                    end
                end
                rpt.next_sync_time = TIME_W'(best);
            end
            OP_MARK: begin
                has_rpt = 1'b1;
                lo_occ = NUM_BINS;
                hi_occ = 0;
                lo_grv = NUM_BINS;
                hi_grv = 0;
                lo_act = NUM_BINS;
                hi_act = 0;
                hi_syn = 0;
                syn_g = 0;
                syn_h = 0;
                tot_g = 0;
                tot_h = 0;
                for (n = 0; n < NUM_BINS; n++) begin
                    occ = (bin_grav[n] != 0) || (bin_hydro[n] != 0);
                    syn = (t & ((64'd1 << n) - 1)) == 0;
                    if (bin_grav[n] != 0) begin
                        hi_grv = n;
                        if (lo_grv == NUM_BINS)
                            lo_grv = n;
                    end
                    if (occ) begin
                        hi_occ = n;
                        if (lo_occ == NUM_BINS)
                            lo_occ = n;
                    end
                    if (syn) begin
                        rpt.synchronized_mask[n] = 1'b1;
                        syn_g = syn_g + bin_grav[n];
                        if (syn_g > MAX_PARTICLES)
                            syn_g = MAX_PARTICLES;
                        syn_h = syn_h + bin_hydro[n];
                        if (syn_h > MAX_PARTICLES)
                            syn_h = MAX_PARTICLES;
                        hi_syn = n;
                        if (occ) begin
                            hi_act = n;
                            if (lo_act == NUM_BINS)
                                lo_act = n;
                        end
                    end
                    tot_g = tot_g + bin_grav[n];
                    tot_h = tot_h + bin_hydro[n];
                    cum_g[n] = tot_g;
                    cum_h[n] = tot_h;
                end
                dbin = hi_occ;
                for (n = hi_occ; n >= lo_occ; n--) begin
                    if ((cum_g[n] << FRAC_SH) > frac * tot_g ||
                        (cum_h[n] << FRAC_SH) > frac * tot_h)
                        dbin = n;
                end
                rpt.lowest_occupied          = BIN_W'(lo_occ);
                rpt.highest_occupied         = BIN_W'(hi_occ);
                rpt.lowest_occupied_gravity  = BIN_W'(lo_grv);
                rpt.highest_occupied_gravity = BIN_W'(hi_grv);
                rpt.lowest_active            = BIN_W'(lo_act);
                rpt.highest_active           = BIN_W'(hi_act);
                rpt.highest_synchronized     = BIN_W'(hi_syn);
                rpt.synced_gravity_count     = CNT_W'(syn_g);
                rpt.synced_hydro_count       = CNT_W'(syn_h);
                rpt.decomp_bin               = BIN_W'(dbin);
            end
        endcase
    endtask

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, got_v);
            fails++;
        end
    endfunction

    function automatic t_in_word make_word(logic [1:0] op, logic [BIN_W-1:0] gbin,
                                           logic gas, logic [BIN_W-1:0] hbin,
                                           logic [TIME_W-1:0] t);
        t_in_word w;
        w.operation    = op;
        w.gravity_bin  = gbin;
        w.is_gas       = gas;
        w.hydro_bin    = hbin;
        w.current_time = t;
        return w;
    endfunction

    // mostly low bins so counts pile up, some wide spread, a few out of range
    function automatic logic [BIN_W-1:0] pick_bin();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return BIN_W'($urandom_range(0, 5));
        else if (r < 18)
            return BIN_W'($urandom_range(0, NUM_BINS - 1));
        return BIN_W'($urandom_range(NUM_BINS, 31));
    endfunction

    // random time with a random number of low zero bits, sometimes zero
    function automatic logic [TIME_W-1:0] pick_time();
        logic [TIME_W-1:0] t;
        int k;
        t = TIME_W'($urandom);
        k = $urandom_range(0, 31);
        if (k == 30)
            t = '0;
        else if (k < 30)
            t = (t >> k) << k;
        return t;
    endfunction

    function automatic t_in_word rand_word();
        int r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < 2)
            op = OP_CLEAR;
        else if (r < 72)
            op = OP_COUNT;
        else if (r < 86)
            op = OP_SYNC;
        else
            op = OP_MARK;
        return make_word(op, pick_bin(), 1'($urandom_range(0, 1)), pick_bin(), pick_time());
    endfunction

    task automatic queue_word(input t_in_word w);
        word_backlog.push_back(w);
        words_queued++;
    endtask

    task automatic drain_and_settle();
        while (words_accepted != words_queued || sync_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_fraction(input logic [FRAC_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        frac_q16 = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // input driver
    always @(posedge clk) begin
        bit        has_rpt;
        t_out_word rpt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                sched_step(in_word, has_rpt, rpt);
                if (has_rpt)
                    sync_reports.push_back(rpt);
                words_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (word_backlog.size() != 0) begin
                    in_word  <= word_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 9);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (sync_reports.size() == 0) begin
                    $error("result word with no prediction pending");
                    fails++;
                end else begin
                    want = sync_reports.pop_front();
                    check_field("next_sync_time", want.next_sync_time,
                                out_word.next_sync_time);
                    check_field("synchronized_mask", want.synchronized_mask,
                                out_word.synchronized_mask);
                    check_field("lowest_occupied", want.lowest_occupied,
                                out_word.lowest_occupied);
                    check_field("highest_occupied", want.highest_occupied,
                                out_word.highest_occupied);
                    check_field("lowest_occupied_gravity", want.lowest_occupied_gravity,
                                out_word.lowest_occupied_gravity);
                    check_field("highest_occupied_gravity", want.highest_occupied_gravity,
                                out_word.highest_occupied_gravity);
                    check_field("lowest_active", want.lowest_active,
                                out_word.lowest_active);
                    check_field("highest_active", want.highest_active,
                                out_word.highest_active);
                    check_field("highest_synchronized", want.highest_synchronized,
                                out_word.highest_synchronized);
                    check_field("synced_gravity_count", want.synced_gravity_count,
                                out_word.synced_gravity_count);
                    check_field("synced_hydro_count", want.synced_hydro_count,
                                out_word.synced_hydro_count);
                    check_field("decomp_bin", want.decomp_bin, out_word.decomp_bin);
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    out_gap = $urandom_range(1, 9);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[timebin_sync_scheduler] ERROR");
            $finish;
        end
    end

    initial begin
        logic [FRAC_W-1:0] fractions [6];
        int p;
        int i;
        for (i = 0; i < NUM_BINS; i++) begin
            bin_grav[i] = '0;
            bin_hydro[i] = '0;
        end
        fractions[0] = '0;
        fractions[1] = FRAC_W'(65536);
        fractions[2] = '1;
        fractions[3] = FRAC_W'(32768);
        fractions[4] = FRAC_W'($urandom_range(0, 131071));
        fractions[5] = FRAC_W'(1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty scheduler, both range ends, dropped bins, hydro-only bins
        queue_word(make_word(OP_MARK, 5'd0, 1'b0, 5'd0, '0));
        queue_word(make_word(OP_SYNC, 5'd3, 1'b1, 5'd3, TIME_W'(77)));
        queue_word(make_word(OP_COUNT, 5'd0, 1'b1, LAST_BIN, '0));
        queue_word(make_word(OP_COUNT, LAST_BIN, 1'b0, 5'd5, '1));
        queue_word(make_word(OP_COUNT, NO_BIN, 1'b1, 5'd3, '0));
        queue_word(make_word(OP_COUNT, 5'd31, 1'b1, 5'd31, '0));
        queue_word(make_word(OP_COUNT, 5'd12, 1'b1, 5'd30, '0));
        queue_word(make_word(OP_SYNC, 5'd0, 1'b0, 5'd0, '0));
        queue_word(make_word(OP_SYNC, 5'd0, 1'b0, 5'd0, '1));
        queue_word(make_word(OP_MARK, 5'd31, 1'b1, 5'd31, '0));
        queue_word(make_word(OP_MARK, 5'd0, 1'b0, 5'd0, '1));
        queue_word(make_word(OP_MARK, 5'd0, 1'b0, 5'd0, TIME_W'(1 << 28)));
        queue_word(make_word(OP_SYNC, 5'd0, 1'b0, 5'd0, TIME_W'((1 << 28) + 5)));
        queue_word(make_word(OP_CLEAR, 5'd31, 1'b1, 5'd31, '1));
        queue_word(make_word(OP_MARK, 5'd0, 1'b0, 5'd0, TIME_W'(12345)));
        queue_word(make_word(OP_COUNT, 5'd3, 1'b0, 5'd9, '0));
        queue_word(make_word(OP_COUNT, 5'd31, 1'b1, 5'd7, '0));
        queue_word(make_word(OP_MARK, 5'd0, 1'b0, 5'd0, TIME_W'(8)));
        queue_word(make_word(OP_SYNC, 5'd0, 1'b0, 5'd0, TIME_W'(7)));
        queue_word(make_word(OP_COUNT, 5'd0, 1'b1, 5'd0, '0));
        queue_word(make_word(OP_SYNC, 5'd0, 1'b0, 5'd0, TIME_W'(1000001)));
        queue_word(make_word(OP_MARK, 5'd0, 1'b0, 5'd0, TIME_W'(1000000)));
        drain_and_settle();

        for (p = 0; p < 6; p++) begin
            write_fraction(fractions[p]);
            if (p == 5)
                calm = 1'b1;
            for (i = 0; i < PHASE_WORDS; i++)
                queue_word(rand_word());
            drain_and_settle();
        end

        if (fails == 0 && sync_reports.size() == 0)
            $display("[timebin_sync_scheduler] OK");
        else
            $display("[timebin_sync_scheduler] ERROR");
        $finish;
    end

endmodule
